FILE: sv/key_sorter_unit_defines.svh
// Assertion macros used by the sorter RTL.
`ifndef KEY_SORTER_UNIT_DEFINES_SVH
`define KEY_SORTER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// Property must hold at every clock edge outside reset.
`define KSU_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);
// Condition must never be seen at a clock edge outside reset.
`define KSU_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(cond)) else $error(msg);
`else
`define KSU_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define KSU_ASSERT_NEVER(lbl, clk_s, rst_s, cond, msg)
`endif

`endif

FILE: sv/ks_pkg.sv
`default_nettype none

package ks_pkg;

  // Width of the key fields on the ports
  localparam int KEY_W = 32;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic             last;
  } in_beat_t;

  typedef struct packed {
    logic [KEY_W-1:0] sorted_key;
    logic             final_res;
    logic             dropped;
  } out_beat_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_ROT   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  // Operation broadcast to every cell of the chain
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_SHIFT  = 2'd2,
    OP_ROTATE = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     mode;
  } cell_ctl_t;

endpackage

`default_nettype wire

FILE: sv/key_sorter_unit.sv
// Key sorter.
// Input channel (in_valid / in_stall / in_data): one key per beat; a beat
// with last set closes the set. Keys are taken at one per cycle while the
// block is loading. Keys beyond DEPTH are discarded and every result of
// that set carries dropped.
// Output channel (out_valid / out_stall / out_data): the keys of the closed
// set in ascending order, one per beat, final_res set on the last one.
// cfg_we / cfg_data select unsigned (0) or two's complement (1) order.
// Each key is placed into a row of DEPTH compare cells as it arrives. After
// the closing beat the head key is registered as the first result and the
// rest follow one per cycle while the receiver does not stall, set by the
// shift of the cell row toward its head. If the order was changed while the
// set was open, the row is first rotated head to tail into the new order.
// A new set is accepted once the row is empty. A stalled receiver holds the
// output register and the row.
// Reset (rst, synchronous) empties the row, clears the set and selects
// unsigned order.
`default_nettype none
`include "key_sorter_unit_defines.svh"

module key_sorter_unit import ks_pkg::*; #(
  parameter int DEPTH    = 64,
  parameter int KEY_BITS = 32
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_beat_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_beat_t      out_data,
  input  wire logic      cfg_we,
  input  wire logic      cfg_data
);

  localparam int CW = $clog2(DEPTH + 1);

  state_t              state, state_next;
  logic [CW-1:0]       count, count_next;
  logic [CW-1:0]       rot_left, rot_left_next;
  logic                overflow, overflow_next;
  logic                drop_set, drop_set_next;
  logic                set_mode, set_mode_next;
  logic                signed_keys;
  cell_ctl_t           ctl;
  logic                in_acc;
  logic                full;
  logic                pop;
  logic [KEY_BITS-1:0] key_in;
  logic [KEY_W-1:0]    key_out;

  logic [KEY_BITS-1:0] cell_key [DEPTH];
  logic [DEPTH-1:0]    cell_vld;
  logic [DEPTH-1:0]    cell_lt;

  // Fit the port key to the stored width and back
  generate
    if (KEY_BITS <= KEY_W) begin : g_narrow
      assign key_in  = in_data.key[KEY_BITS-1:0];
      assign key_out = KEY_W'(cell_key[0]);
    end else begin : g_wide
      assign key_in  = KEY_BITS'(in_data.key);
      assign key_out = cell_key[0][KEY_W-1:0];
    end
  endgenerate

  assign in_stall = (state != ST_LOAD);
  assign in_acc   = in_valid && !in_stall;
  assign full     = (count == CW'(DEPTH));
  assign pop      = (state == ST_DRAIN) && cell_vld[0] && (!out_valid || !out_stall);

  // Order register
  always_ff @(posedge clk) begin
    if (rst) begin
      signed_keys <= 1'b0;
    end else if (cfg_we) begin
      signed_keys <= cfg_data;
    end
  end

  // Sequencer: load, optional rotation, drain
  always_comb begin
    state_next    = state;
    count_next    = count;
    rot_left_next = rot_left;
    overflow_next = overflow;
    drop_set_next = drop_set;
    set_mode_next = set_mode;
    ctl.op        = OP_HOLD;
    ctl.mode      = (count == '0) ? signed_keys : set_mode;
    unique case (state)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            overflow_next = 1'b1;
          end else begin
            ctl.op        = OP_INSERT;
            count_next    = count + CW'(1);
            set_mode_next = ctl.mode;
          end
          if (in_data.last) begin
            drop_set_next = overflow_next;
            rot_left_next = count_next;
            count_next    = '0;
            overflow_next = 1'b0;
            state_next    = (ctl.mode != signed_keys) ? ST_ROT : ST_DRAIN;
          end
        end
      end
      ST_ROT: begin
        if (rot_left == '0 || cell_key[0][KEY_BITS-1] == signed_keys) begin
          state_next = ST_DRAIN;
        end else begin
          ctl.op        = OP_ROTATE;
          rot_left_next = rot_left - CW'(1);
        end
      end
      ST_DRAIN: begin
        if (pop) begin
          ctl.op = OP_SHIFT;
          if (!cell_vld[1]) begin
            state_next = ST_LOAD;
          end
        end
      end
      default: begin
        state_next = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_LOAD;
      count    <= '0;
      rot_left <= '0;
      overflow <= 1'b0;
      drop_set <= 1'b0;
      set_mode <= 1'b0;
    end else begin
      state    <= state_next;
      count    <= count_next;
      rot_left <= rot_left_next;
      overflow <= overflow_next;
      drop_set <= drop_set_next;
      set_mode <= set_mode_next;
    end
  end

  // Row of compare cells, head at index 0
  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [KEY_BITS-1:0] l_key;
      logic                l_vld;
      logic                l_lt;
      logic [KEY_BITS-1:0] r_key;
      logic                r_vld;
      if (i == 0) begin : g_head
        assign l_key = '0;
        assign l_vld = 1'b0;
        assign l_lt  = 1'b0;
      end else begin : g_left
        assign l_key = cell_key[i-1];
        assign l_vld = cell_vld[i-1];
        assign l_lt  = cell_lt[i-1];
      end
      if (i == DEPTH - 1) begin : g_tail
        assign r_key = '0;
        assign r_vld = 1'b0;
      end else begin : g_right
        assign r_key = cell_key[i+1];
        assign r_vld = cell_vld[i+1];
      end
      ks_cell #(.KEY_BITS(KEY_BITS)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .ctl       (ctl),
        .new_key   (key_in),
        .left_key  (l_key),
        .left_vld  (l_vld),
        .left_lt   (l_lt),
        .right_key (r_key),
        .right_vld (r_vld),
        .head_key  (cell_key[0]),
        .key       (cell_key[i]),
        .vld       (cell_vld[i]),
        .lt        (cell_lt[i])
      );
    end
  endgenerate

  // Output register: load on pop, drop the beat once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data.sorted_key <= key_out;
      out_data.final_res  <= !cell_vld[1];
      out_data.dropped    <= drop_set;
    end
  end

  `KSU_ASSERT(a_rot_ends, clk, rst, state == ST_ROT && rot_left == '0 |=> state == ST_DRAIN, "rotation did not end")
  `KSU_ASSERT_NEVER(a_row_gap, clk, rst, (cell_vld & (cell_vld + DEPTH'(1))) != '0, "gap in cell row")
  `KSU_ASSERT(a_load_count, clk, rst, state == ST_LOAD |-> $countones(cell_vld) == count, "count differs from row")

endmodule

`default_nettype wire

FILE: sv/ks_cell.sv
`default_nettype none

module ks_cell import ks_pkg::*; #(
  parameter int KEY_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire cell_ctl_t           ctl,
  input  wire logic [KEY_BITS-1:0] new_key,
  input  wire logic [KEY_BITS-1:0] left_key,
  input  wire logic                left_vld,
  input  wire logic                left_lt,
  input  wire logic [KEY_BITS-1:0] right_key,
  input  wire logic                right_vld,
  input  wire logic [KEY_BITS-1:0] head_key,
  output logic [KEY_BITS-1:0]      key,
  output logic                     vld,
  output logic                     lt
);

  localparam logic [KEY_BITS-1:0] SIGN = {1'b1, {(KEY_BITS-1){1'b0}}};

  logic [KEY_BITS-1:0] ord_new;
  logic [KEY_BITS-1:0] ord_own;
  logic                is_tail;

  // Flip the sign bit so two's complement order becomes unsigned order
  assign ord_new = ctl.mode ? (new_key ^ SIGN) : new_key;
  assign ord_own = ctl.mode ? (key ^ SIGN) : key;

  // An empty cell acts as plus infinity
  assign lt      = !vld || (ord_new < ord_own);
  assign is_tail = vld && !right_vld;

  // Insert, shift toward the head, or rotate the head to the tail
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else begin
      unique case (ctl.op)
        OP_INSERT: begin
          if (left_lt) begin
            key <= left_key;
            vld <= left_vld;
          end else if (lt) begin
            key <= new_key;
            vld <= 1'b1;
          end
        end
        OP_SHIFT: begin
          key <= right_key;
          vld <= right_vld;
        end
        OP_ROTATE: begin
          if (is_tail) begin
            key <= head_key;
          end else begin
            key <= right_key;
            vld <= right_vld;
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: bench/testbench.sv
`default_nettype none

module testbench;
  import ks_pkg::*;

  localparam int SORT_DEPTH  = 64;
  localparam int SORT_BITS   = 32;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 24;
  localparam int LONG_HOLD   = 500;
  localparam int SETTLE      = 3 * SORT_DEPTH + 16;
  localparam int CYCLE_LIMIT = 1000000;

  // Key flavors for stimulus
  localparam int KF_RANDOM   = 0;
  localparam int KF_TINY     = 1;
  localparam int KF_SIGN_MID = 2;
  localparam int KF_CORNER   = 3;
  localparam int KF_TOP      = 4;
  localparam int KF_MIXED    = 5;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_beat_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_beat_t out_data;
  logic      cfg_we    = 1'b0;
  logic      cfg_data  = 1'b0;

  // Pending stimulus and expected sorted output
  in_beat_t  key_feed[$];
  out_beat_t pending_sorted[$];

  // Shadow of the open set and the order register
  logic [KEY_W-1:0] open_keys[SORT_DEPTH];
  int               open_count   = 0;
  logic             open_dropped = 1'b0;
  logic             signed_mode  = 1'b0;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int hold_req      = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int error_count   = 0;

  key_sorter_unit #(
    .DEPTH    (SORT_DEPTH),
    .KEY_BITS (SORT_BITS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Store one accepted key; on a closing beat sort the set and queue its results
  task automatic predict_sorted(input in_beat_t beat);
    logic [KEY_W-1:0] v;
    logic [KEY_W-1:0] flip;
    out_beat_t        res;
    int               n;
    int               j;
    if (open_count < SORT_DEPTH) begin
      open_keys[open_count] = beat.key;
      open_count++;
    end else begin
      open_dropped = 1'b1;
    end
    if (beat.last) begin
      // flip the sign bit so unsigned compare gives two's complement order
      flip = signed_mode ? {1'b1, {(KEY_W-1){1'b0}}} : '0;
      n = open_count;
      for (int i = 1; i < n; i++) begin
        v = open_keys[i];
        j = i;
        while (j > 0 && ((open_keys[j-1] ^ flip) > (v ^ flip))) begin
          open_keys[j] = open_keys[j-1];
          j--;
        end
        open_keys[j] = v;
      end
      for (int i = 0; i < n; i++) begin
        res.sorted_key = open_keys[i];
        res.final_res  = (i == n - 1);
        res.dropped    = open_dropped;
        pending_sorted.push_back(res);
      end
      open_count   = 0;
      open_dropped = 1'b0;
    end
  endtask

  function automatic logic [KEY_W-1:0] pick_key(input int flavor);
    logic [KEY_W-1:0] k;
    case (flavor)
      KF_TINY:     k = KEY_W'($urandom_range(0, 7));
      KF_SIGN_MID: k = 32'h7FFF_FFFC + KEY_W'($urandom_range(0, 7));
      KF_TOP:      k = 32'hFFFF_FFF8 + KEY_W'($urandom_range(0, 7));
      KF_CORNER: begin
        case ($urandom_range(0, 5))
          0:       k = 32'h0000_0000;
          1:       k = 32'h0000_0001;
          2:       k = 32'h7FFF_FFFF;
          3:       k = 32'h8000_0000;
          4:       k = 32'hFFFF_FFFE;
          default: k = 32'hFFFF_FFFF;
        endcase
      end
      default:     k = KEY_W'($urandom);
    endcase
    return k;
  endfunction

  // Queue one set of n keys, last flag on the final one
  task automatic queue_set(input int n, input int flavor);
    in_beat_t beat;
    for (int i = 0; i < n; i++) begin
      beat.key  = (flavor == KF_MIXED) ? pick_key($urandom_range(0, 4)) : pick_key(flavor);
      beat.last = (i == n - 1);
      key_feed.push_back(beat);
    end
  endtask

  task automatic queue_key(input logic [KEY_W-1:0] k, input logic closing);
    in_beat_t beat;
    beat.key  = k;
    beat.last = closing;
    key_feed.push_back(beat);
  endtask

  // Wait for all beats sent and all results seen, then let the block settle
  task automatic drain_and_settle();
    do begin
      @(negedge clk);
    end while (key_feed.size() != 0 || in_valid || pending_sorted.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_order(input logic mode);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= mode;
    @(posedge clk);
    cfg_we   <= 1'b0;
    signed_mode = mode;
  endtask

  // Drive input beats; hold the payload while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_sorted(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (key_feed.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= key_feed.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Check output beats and drive the receiver stall
  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_sorted.size() == 0) begin
          $error("unexpected beat: sorted_key %h final_res %b dropped %b",
                 out_data.sorted_key, out_data.final_res, out_data.dropped);
          error_count++;
        end else begin
          want = pending_sorted.pop_front();
          if (out_data.sorted_key !== want.sorted_key) begin
            $error("sorted_key: expected %h, got %h", want.sorted_key, out_data.sorted_key);
            error_count++;
          end
          if (out_data.final_res !== want.final_res) begin
            $error("final_res: expected %b, got %b", want.final_res, out_data.final_res);
            error_count++;
          end
          if (out_data.dropped !== want.dropped) begin
            $error("dropped: expected %b, got %b", want.dropped, out_data.dropped);
            error_count++;
          end
        end
      end
      // start a long hold on request, else stall at random
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= LONG_HOLD;
        out_stall <= 1'b1;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int sent;
    int n;
    int r;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // single key passes through
    queue_key(32'hDEAD_BEEF, 1'b1);

    // extremes in unsigned order, with a duplicate
    queue_key(32'hFFFF_FFFF, 1'b0);
    queue_key(32'h8000_0000, 1'b0);
    queue_key(32'h0000_0000, 1'b0);
    queue_key(32'h7FFF_FFFF, 1'b0);
    queue_key(32'h0000_0001, 1'b0);
    queue_key(32'h8000_0000, 1'b1);
    drain_and_settle();

    // same extremes in two's complement order
    write_order(1'b1);
    queue_key(32'hFFFF_FFFF, 1'b0);
    queue_key(32'h8000_0000, 1'b0);
    queue_key(32'h0000_0000, 1'b0);
    queue_key(32'h7FFF_FFFF, 1'b0);
    queue_key(32'h0000_0001, 1'b0);
    queue_key(32'h8000_0000, 1'b1);

    // order changed while the set is open: the value at closing decides
    queue_key(32'hFFFF_FFFF, 1'b0);
    queue_key(32'h0000_0001, 1'b0);
    queue_key(32'h8000_0000, 1'b0);
    drain_and_settle();
    write_order(1'b0);
    queue_key(32'h7FFF_FFFF, 1'b0);
    queue_key(32'h0000_0002, 1'b1);

    // two equal keys
    queue_key(32'h5A5A_5A5A, 1'b0);
    queue_key(32'h5A5A_5A5A, 1'b1);

    // random sets over idle patterns and both orders
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_and_settle();
      write_order(1'(((ph + 1) / 2) % 2));
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 86; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 86; end
        default: begin send_idle_pct = 9; stall_pct = 9; end
      endcase
      sent = 0;
      if (ph == 0) begin
        // full set plus a discarded closing key, behind a long receiver hold
        hold_req++;
        queue_set(SORT_DEPTH + 1, KF_MIXED);
        sent = SORT_DEPTH + 1;
      end
      while (sent < PHASE_ITEMS) begin
        r = $urandom_range(0, 99);
        if (r < 60)      n = $urandom_range(1, 8);
        else if (r < 85) n = $urandom_range(9, 24);
        else if (r < 95) n = $urandom_range(25, SORT_DEPTH - 1);
        else if (r < 98) n = SORT_DEPTH;
        else             n = $urandom_range(SORT_DEPTH + 1, SORT_DEPTH + 6);
        queue_set(n, $urandom_range(KF_RANDOM, KF_MIXED));
        sent += n;
      end
    end

    drain_and_settle();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
